// ----- hw/rtl/imh_pkg.sv -----
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants of the indexed min-heap
// Field widths, status codes and the default sizes of the heap.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int KEY_W      = 64;
	localparam int OWNER_W    = 10;
	localparam int TOTAL_W    = 11;
	localparam int STATUS_W   = 2;

	localparam int CAPACITY_DEF    = 1024;
	localparam int OWNER_COUNT_DEF = 1024;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

	localparam logic OP_UPSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [OWNER_W-1:0] owner_id;
		logic [KEY_W-1:0]   key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]    top_key;
		logic [OWNER_W-1:0]  top_owner;
		logic [TOTAL_W-1:0]  entry_total;
		logic                is_empty;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// ----- hw/rtl/imh_req_if.sv -----
// ----------------------------------------------------------------------------
// imh_req_if: request channel
// Valid/ready channel that carries one heap request per transaction.
// ----------------------------------------------------------------------------
interface imh_req_if import imh_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [OWNER_W-1:0] owner_id;
	logic [KEY_W-1:0]   key;

	modport source (output valid, operation, owner_id, key, input ready);
	modport sink   (input valid, operation, owner_id, key, output ready);
endinterface

// ----- hw/rtl/imh_rsp_if.sv -----
// ----------------------------------------------------------------------------
// imh_rsp_if: response channel
// Valid/ready channel that carries one heap response per transaction.
// ----------------------------------------------------------------------------
interface imh_rsp_if import imh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KEY_W-1:0]    top_key;
	logic [OWNER_W-1:0]  top_owner;
	logic [TOTAL_W-1:0]  entry_total;
	logic                is_empty;
	logic [STATUS_W-1:0] status;

	modport source (output valid, top_key, top_owner, entry_total, is_empty, status,
		input ready);
	modport sink   (input valid, top_key, top_owner, entry_total, is_empty, status,
		output ready);
endinterface

// ----- hw/rtl/imh_heap_mem.sv -----
// ----------------------------------------------------------------------------
// imh_heap_mem: heap slot store
// One write port and one registered read port for key and owner of each slot.
// ----------------------------------------------------------------------------
module imh_heap_mem import imh_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int SLOT_W   = $clog2(CAPACITY)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  logic [KEY_W-1:0]  wkey,
	input  logic [OWNER_W-1:0] wown,
	input  logic [SLOT_W-1:0] raddr,
	output logic [KEY_W-1:0]  rkey,
	output logic [OWNER_W-1:0] rown
);
	logic [KEY_W+OWNER_W-1:0] mem [CAPACITY];
	logic [KEY_W+OWNER_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wown};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rkey = rdata_q[KEY_W+OWNER_W-1:OWNER_W];
	assign rown = rdata_q[OWNER_W-1:0];
endmodule

// ----- hw/rtl/indexed_min_heap_core.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_core: indexed binary min-heap of 64-bit keys
// Upsert or delete one owner's entry per request, answer with the minimum.
// ----------------------------------------------------------------------------
// Usage:
//   req: one transaction per request (operation, owner_id, key). ready is low
//   while a request is being worked; one request at a time.
//   rsp: one transaction per request with top_key, top_owner, entry_total,
//   is_empty and status.
// Walk: a sequencer walks the heap with one comparator and a slot memory
//   with one registered read port. A level going up reads the parent, waits,
//   then compares and moves; a level going down reads the left child,
//   compares, reads the right child, compares and moves. The longest walk
//   is a delete that sifts from the root to a leaf.
// Reset: clears the entry count and the owner-present bits; no request is
//   accepted during the clearing pass over the present bits. Slot and
//   position stores need no clearing.
// Stall: the response is held in an output register until taken; the next
//   request is accepted once the response has gone.
// ----------------------------------------------------------------------------
module indexed_min_heap_core import imh_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int OWNER_COUNT = OWNER_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	imh_req_if.sink    req,
	imh_rsp_if.source  rsp
);
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int OID_W  = $clog2(OWNER_COUNT);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// sequencer states
	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_LOOK   = 5'd2;
	localparam logic [4:0] S_POS    = 5'd3;
	localparam logic [4:0] S_DLAST  = 5'd4;
	localparam logic [4:0] S_DLASTW = 5'd5;
	localparam logic [4:0] S_RS     = 5'd6;
	localparam logic [4:0] S_RSW    = 5'd7;
	localparam logic [4:0] S_RSC    = 5'd8;
	localparam logic [4:0] S_UPR    = 5'd9;
	localparam logic [4:0] S_UPW    = 5'd10;
	localparam logic [4:0] S_UPC    = 5'd11;
	localparam logic [4:0] S_DNL    = 5'd12;
	localparam logic [4:0] S_DNLW   = 5'd13;
	localparam logic [4:0] S_DNR    = 5'd14;
	localparam logic [4:0] S_DNRW   = 5'd15;
	localparam logic [4:0] S_DNC    = 5'd16;
	localparam logic [4:0] S_PLACE  = 5'd17;
	localparam logic [4:0] S_TOPR   = 5'd18;
	localparam logic [4:0] S_TOPW   = 5'd19;
	localparam logic [4:0] S_RESP   = 5'd20;

	logic [4:0] state_q;

	// owner stores: present bits (memory with clearing pass), positions
	logic              pres_mem [OWNER_COUNT];
	logic [SLOT_W-1:0] pos_mem  [OWNER_COUNT];
	logic              pres_rd_q;
	logic [SLOT_W-1:0] pos_rd_q;
	logic              pres_we;
	logic [OID_W-1:0]  pres_waddr;
	logic              pres_wdata;
	logic              pos_we;
	logic [OID_W-1:0]  pos_waddr;
	logic [SLOT_W-1:0] pos_wdata;
	logic [OID_W-1:0]  own_raddr;
	logic [OID_W-1:0]  clr_q;

	// request and walk registers
	logic               op_q;
	logic [OWNER_W-1:0] own_q;
	logic [KEY_W-1:0]   key_q;
	logic               oor_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [KEY_W-1:0]   mkey_q;
	logic [OWNER_W-1:0] mown_q;
	logic [SLOT_W:0]    best_q;
	logic [KEY_W-1:0]   bkey_q;
	logic [OWNER_W-1:0] bown_q;
	logic [STATUS_W-1:0] status_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	// slot memory
	logic               hm_we;
	logic [SLOT_W-1:0]  hm_waddr;
	logic [KEY_W-1:0]   hm_wkey;
	logic [OWNER_W-1:0] hm_wown;
	logic [SLOT_W-1:0]  hm_raddr;
	logic [KEY_W-1:0]   hm_rkey;
	logic [OWNER_W-1:0] hm_rown;

	imh_heap_mem #(.CAPACITY(CAPACITY), .SLOT_W(SLOT_W)) u_mem (
		.clk(clk), .we(hm_we), .waddr(hm_waddr), .wkey(hm_wkey), .wown(hm_wown),
		.raddr(hm_raddr), .rkey(hm_rkey), .rown(hm_rown)
	);

	// derived walk addresses
	logic [SLOT_W:0] left_w, right_w, parent_w;
	logic            cmp_lt;
	logic [KEY_W-1:0] cmp_a, cmp_b;
	assign left_w   = {slot_q, 1'b1};
	assign right_w  = {slot_q, 1'b0} + {{SLOT_W{1'b0}}, 1'b1} + {{SLOT_W{1'b0}}, 1'b1};
	assign parent_w = {1'b0, (slot_q - {{(SLOT_W-1){1'b0}}, 1'b1}) >> 1};

	// the shared comparator: cmp_a < cmp_b
	assign cmp_lt = cmp_a < cmp_b;
	always_comb begin
		cmp_a = hm_rkey;
		cmp_b = mkey_q;
		case (state_q)
			S_RSC, S_UPC: begin
				cmp_a = mkey_q;
				cmp_b = hm_rkey;
			end
			S_DNLW: begin
				cmp_a = hm_rkey;
				cmp_b = mkey_q;
			end
			S_DNRW: begin
				cmp_a = hm_rkey;
				cmp_b = bkey_q;
			end
			default: begin
				cmp_a = hm_rkey;
				cmp_b = mkey_q;
			end
		endcase
	end

	// owner stores, clocked access
	always_ff @(posedge clk) begin
		if (pres_we) begin
			pres_mem[pres_waddr] <= pres_wdata;
		end
		if (pos_we) begin
			pos_mem[pos_waddr] <= pos_wdata;
		end
		pres_rd_q <= pres_mem[own_raddr];
		pos_rd_q  <= pos_mem[own_raddr];
	end

	// owner lookup follows the held request once it is taken
	assign own_raddr = (state_q == S_IDLE) ? req.owner_id[OID_W-1:0] : own_q[OID_W-1:0];
	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.top_key     = rsp_q.top_key;
	assign rsp.top_owner   = rsp_q.top_owner;
	assign rsp.entry_total = rsp_q.entry_total;
	assign rsp.is_empty    = rsp_q.is_empty;
	assign rsp.status      = rsp_q.status;

	// memory port control; the read address is held through the wait cycle
	always_comb begin
		hm_we      = 1'b0;
		hm_waddr   = slot_q;
		hm_wkey    = bkey_q;
		hm_wown    = bown_q;
		hm_raddr   = slot_q;
		pres_we    = 1'b0;
		pres_waddr = own_q[OID_W-1:0];
		pres_wdata = 1'b0;
		pos_we     = 1'b0;
		pos_waddr  = bown_q[OID_W-1:0];
		pos_wdata  = slot_q;
		case (state_q)
			S_CLEAR: begin
				pres_we    = 1'b1;
				pres_waddr = clr_q;
			end
			S_DLAST: hm_raddr = SLOT_W'(cnt_q);
			S_RS, S_RSW, S_RSC: hm_raddr = parent_w[SLOT_W-1:0];
			S_UPR, S_UPW:       hm_raddr = parent_w[SLOT_W-1:0];
			S_DNL:   hm_raddr = left_w[SLOT_W-1:0];
			S_DNR:   hm_raddr = right_w[SLOT_W-1:0];
			S_TOPR, S_TOPW: hm_raddr = '0;
			S_UPC, S_DNC: begin
				// move the chosen neighbor into the current slot
				hm_we     = (state_q == S_UPC) ? cmp_lt : (best_q != {1'b0, slot_q});
				hm_wkey   = (state_q == S_UPC) ? hm_rkey : bkey_q;
				hm_wown   = (state_q == S_UPC) ? hm_rown : bown_q;
				pos_we    = hm_we && (32'(hm_wown) < OWNER_COUNT);
				pos_waddr = hm_wown[OID_W-1:0];
			end
			S_PLACE: begin
				hm_we     = 1'b1;
				hm_wkey   = mkey_q;
				hm_wown   = mown_q;
				pos_we    = 32'(mown_q) < OWNER_COUNT;
				pos_waddr = mown_q[OID_W-1:0];
			end
			S_POS: begin
				if (!oor_q && op_q == OP_UPSERT && !pres_rd_q
						&& 32'(cnt_q) < CAPACITY) begin
					pres_we    = 1'b1;
					pres_wdata = 1'b1;
				end
				if (!oor_q && op_q == OP_DELETE && pres_rd_q) begin
					pres_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == OWNER_COUNT - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						op_q     <= req.operation;
						own_q    <= req.owner_id;
						key_q    <= req.key;
						oor_q    <= 32'(req.owner_id) >= OWNER_COUNT;
						status_q <= ST_OK;
						state_q  <= S_LOOK;
					end
				end
				S_LOOK: state_q <= S_POS;
				S_POS: begin
					// decide the request; owner stores read data now valid
					mkey_q  <= key_q;
					mown_q  <= own_q;
					if (oor_q) begin
						status_q <= ST_ABSENT;
						state_q  <= S_TOPR;
					end else if (op_q == OP_UPSERT) begin
						if (pres_rd_q) begin
							slot_q  <= pos_rd_q;
							state_q <= (CNT_W'(pos_rd_q) < cnt_q) ? S_RS : S_TOPR;
						end else if (32'(cnt_q) >= CAPACITY) begin
							status_q <= ST_FULL;
							state_q  <= S_TOPR;
						end else begin
							slot_q  <= SLOT_W'(cnt_q);
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_RS;
						end
					end else begin
						if (!pres_rd_q) begin
							status_q <= ST_ABSENT;
							state_q  <= S_TOPR;
						end else begin
							slot_q <= pos_rd_q;
							if (CNT_W'(pos_rd_q) < cnt_q) begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= (CNT_W'(pos_rd_q) < cnt_q - 1'b1) ? S_DLAST
									: S_TOPR;
							end else begin
								state_q <= S_TOPR;
							end
						end
					end
				end
				S_DLAST: state_q <= S_DLASTW;
				S_DLASTW: begin
					mkey_q  <= hm_rkey;
					mown_q  <= hm_rown;
					state_q <= S_RS;
				end
				S_RS: begin
					state_q <= (slot_q == '0) ? S_DNL : S_RSW;
				end
				S_RSW: state_q <= S_RSC;
				S_RSC: begin
					// parent greater than moving key: sift up, else down
					state_q <= cmp_lt ? S_UPC : S_DNL;
					best_q  <= {1'b0, slot_q};
					bkey_q  <= mkey_q;
					bown_q  <= mown_q;
				end
				S_UPR: begin
					state_q <= (slot_q == '0) ? S_PLACE : S_UPW;
				end
				S_UPW: state_q <= S_UPC;
				S_UPC: begin
					if (cmp_lt) begin
						slot_q  <= parent_w[SLOT_W-1:0];
						state_q <= S_UPR;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DNL: begin
					best_q <= {1'b0, slot_q};
					bkey_q <= mkey_q;
					bown_q <= mown_q;
					if (CNT_W'(left_w) < cnt_q && left_w <= (SLOT_W+1)'(CAPACITY - 1)) begin
						state_q <= S_DNLW;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DNLW: begin
					if (cmp_lt) begin
						best_q <= left_w;
						bkey_q <= hm_rkey;
						bown_q <= hm_rown;
					end
					state_q <= S_DNR;
				end
				S_DNR: begin
					state_q <= (CNT_W'(right_w) < cnt_q) ? S_DNRW : S_DNC;
				end
				S_DNRW: begin
					if (cmp_lt) begin
						best_q <= right_w;
						bkey_q <= hm_rkey;
						bown_q <= hm_rown;
					end
					state_q <= S_DNC;
				end
				S_DNC: begin
					if (best_q != {1'b0, slot_q}) begin
						slot_q  <= best_q[SLOT_W-1:0];
						state_q <= S_DNL;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: state_q <= S_TOPR;
				S_TOPR:  state_q <= S_TOPW;
				S_TOPW:  state_q <= S_RESP;
				S_RESP: begin
					rsp_q.top_key     <= (cnt_q != '0) ? hm_rkey : '0;
					rsp_q.top_owner   <= (cnt_q != '0) ? hm_rown : '0;
					rsp_q.entry_total <= TOTAL_W'(cnt_q);
					rsp_q.is_empty    <= (cnt_q == '0);
					rsp_q.status      <= status_q;
					rsp_valid_q       <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/imh_checker.sv -----
// ----------------------------------------------------------------------------
// imh_checker: port-level checks of the indexed min-heap
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module imh_checker import imh_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [KEY_W-1:0]    rsp_top_key,
	input logic [OWNER_W-1:0]  rsp_top_owner,
	input logic [TOTAL_W-1:0]  rsp_entry_total,
	input logic                rsp_is_empty,
	input logic [STATUS_W-1:0] rsp_status
);
	// empty flag agrees with the count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_empty == (rsp_entry_total == '0)))
		else $error("is_empty disagrees with entry_total");

	// empty heap reports a zero top
	a_zero_top: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_is_empty) |-> (rsp_top_key == '0 && rsp_top_owner == '0))
		else $error("empty heap with nonzero top");

	// no new request while a response is pending
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request accepted while response pending");

	// status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL
			|| rsp_status == ST_ABSENT))
		else $error("bad status code");

	// a stalled response stays valid and keeps its top key
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_top_key)))
		else $error("stalled response changed");
endmodule

bind indexed_min_heap_core imh_checker u_imh_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_top_key(rsp.top_key), .rsp_top_owner(rsp.top_owner),
	.rsp_entry_total(rsp.entry_total), .rsp_is_empty(rsp.is_empty),
	.rsp_status(rsp.status)
);

// ----- verif/tb_indexed_min_heap_core.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_core: self-checking bench of the indexed min-heap
// A queue-fed driver sends upsert and delete requests across phases of
// sender idling and receiver stalls. A local heap predictor computes each
// expected response, and the monitor checks every response field by field.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_core;
	import imh_pkg::*;

	localparam int SLOTS  = CAPACITY_DEF;
	localparam int OWNERS = OWNER_COUNT_DEF;

	typedef struct {
		req_t req;
		int   gap_pct;
		int   stall_pct;
		bit   drain;
	} pend_item_t;

	logic clk;
	logic arst_n;

	imh_req_if req_ch ();
	imh_rsp_if rsp_ch ();

	indexed_min_heap_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// predictor state
	logic [KEY_W-1:0]   slot_key   [SLOTS];
	logic [OWNER_W-1:0] slot_owner [SLOTS];
	int                 owner_slot [OWNERS];
	bit                 owner_live [OWNERS];
	int                 heap_size;

	pend_item_t pending_reqs[$];
	rsp_t       expected_rsps[$];
	int         sent_cnt, taken_cnt, err_cnt, rsp_cnt;
	int         stall_pct;
	int         n_upsert, n_delete, n_absent, peak_size;

	// ---------------- heap predictor ----------------
	function automatic void put_slot(int s, logic [KEY_W-1:0] k, logic [OWNER_W-1:0] o);
		slot_key[s]   = k;
		slot_owner[s] = o;
		owner_slot[o] = s;
	endfunction

	function automatic void sift_toward_root(int s);
		logic [KEY_W-1:0]   k;
		logic [OWNER_W-1:0] o;
		int                 p;
		k = slot_key[s];
		o = slot_owner[s];
		while (s > 0) begin
			p = (s - 1) / 2;
			if (!(slot_key[p] > k)) break;
			put_slot(s, slot_key[p], slot_owner[p]);
			s = p;
		end
		put_slot(s, k, o);
	endfunction

	function automatic void sift_toward_leaves(int s);
		logic [KEY_W-1:0]   k, bk;
		logic [OWNER_W-1:0] o;
		int                 l, r, b;
		k = slot_key[s];
		o = slot_owner[s];
		forever begin
			l  = 2 * s + 1;
			r  = 2 * s + 2;
			b  = s;
			bk = k;
			if (l < heap_size && slot_key[l] < bk) begin
				b  = l;
				bk = slot_key[l];
			end
			if (r < heap_size && slot_key[r] < bk) begin
				b  = r;
				bk = slot_key[r];
			end
			if (b == s) break;
			put_slot(s, slot_key[b], slot_owner[b]);
			s = b;
		end
		put_slot(s, k, o);
	endfunction

	function automatic void rebalance(int s);
		if (s > 0 && slot_key[(s - 1) / 2] > slot_key[s])
			sift_toward_root(s);
		else
			sift_toward_leaves(s);
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   s, last;
		res.status = ST_OK;
		if (r.operation == OP_UPSERT) begin
			n_upsert++;
			if (owner_live[r.owner_id]) begin
				s = owner_slot[r.owner_id];
				slot_key[s] = r.key;
				rebalance(s);
			end else if (heap_size >= SLOTS) begin
				res.status = ST_FULL;
			end else begin
				s = heap_size;
				heap_size++;
				owner_live[r.owner_id] = 1'b1;
				put_slot(s, r.key, r.owner_id);
				rebalance(s);
			end
		end else begin
			n_delete++;
			if (!owner_live[r.owner_id]) begin
				res.status = ST_ABSENT;
			end else begin
				s = owner_slot[r.owner_id];
				owner_live[r.owner_id] = 1'b0;
				last = heap_size - 1;
				heap_size = last;
				if (s < last) begin
					put_slot(s, slot_key[last], slot_owner[last]);
					rebalance(s);
				end
			end
		end
		if (res.status == ST_ABSENT) n_absent++;
		if (heap_size > peak_size) peak_size = heap_size;
		res.top_key     = heap_size > 0 ? slot_key[0] : '0;
		res.top_owner   = heap_size > 0 ? slot_owner[0] : '0;
		res.is_empty    = heap_size == 0;
		res.entry_total = heap_size[TOTAL_W-1:0];
		return res;
	endfunction

	task automatic check_field(string name, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] act_v);
		if (exp_v !== act_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	// ---------------- clock and reset ----------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ---------------- request driver ----------------
	initial begin
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_UPSERT;
		req_ch.owner_id  = '0;
		req_ch.key       = '0;
		rsp_ch.ready     = 1'b0;
		stall_pct        = 0;
	end

	always @(negedge clk) begin
		logic       nv;
		pend_item_t it;
		nv = req_ch.valid;
		if (arst_n && sent_cnt == taken_cnt) begin
			nv = 1'b0;
			if (pending_reqs.size() > 0) begin
				it = pending_reqs[0];
				stall_pct = it.stall_pct;
				if (!(it.drain && expected_rsps.size() > 0) &&
						$urandom_range(99) >= it.gap_pct) begin
					void'(pending_reqs.pop_front());
					req_ch.operation <= it.req.operation;
					req_ch.owner_id  <= it.req.owner_id;
					req_ch.key       <= it.req.key;
					nv = 1'b1;
					sent_cnt++;
				end
			end
		end
		req_ch.valid <= nv;
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// ---------------- monitor and checker ----------------
	always @(posedge clk) begin
		req_t r;
		rsp_t e;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			r.operation = req_ch.operation;
			r.owner_id  = req_ch.owner_id;
			r.key       = req_ch.key;
			expected_rsps = {expected_rsps, apply_request(r)};
			taken_cnt++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_cnt++;
			if (expected_rsps.size() == 0) begin
				err_cnt++;
				$display("%0t: response with none expected, actual key %0h owner %0d", $time,
					rsp_ch.top_key, rsp_ch.top_owner);
			end else begin
				e = expected_rsps.pop_front();
				check_field("top_key", e.top_key, rsp_ch.top_key);
				check_field("top_owner", KEY_W'(e.top_owner), KEY_W'(rsp_ch.top_owner));
				check_field("entry_total", KEY_W'(e.entry_total),
					KEY_W'(rsp_ch.entry_total));
				check_field("is_empty", KEY_W'(e.is_empty), KEY_W'(rsp_ch.is_empty));
				check_field("status", KEY_W'(e.status), KEY_W'(rsp_ch.status));
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic add_req(logic op, int own, logic [KEY_W-1:0] k, int gap, int stall,
			bit drain = 0);
		pend_item_t it;
		it.req.operation = op;
		it.req.owner_id  = own[OWNER_W-1:0];
		it.req.key       = k;
		it.gap_pct       = gap;
		it.stall_pct     = stall;
		it.drain         = drain;
		pending_reqs = {pending_reqs, it};
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(3))
			0: return {60'd0, 4'($urandom_range(7))};
			1: return {$urandom, $urandom};
			2: return {32'hFFFF_FFFF, $urandom};
			default: return 64'($urandom_range(1000));
		endcase
	endfunction

	initial begin
		int gaps[4];
		int stalls[4];
		int dir_own[5];
		int order[OWNERS];
		int j, t, pool;
		logic [KEY_W-1:0] kmax;
		gaps    = '{0, 45, 0, 27};
		stalls  = '{0, 0, 45, 27};
		dir_own = '{0, 2, 341, 682, 1023};
		kmax = '1;
		sent_cnt = 0; taken_cnt = 0; err_cnt = 0; rsp_cnt = 0;
		heap_size = 0; peak_size = 0; n_upsert = 0; n_delete = 0; n_absent = 0;
		foreach (owner_live[i]) owner_live[i] = 1'b0;

		// directed: extremes, equal keys, in-place moves, absent deletes
		add_req(OP_DELETE, 5, kmax, 0, 0);
		add_req(OP_UPSERT, 1023, kmax, 0, 0);
		add_req(OP_UPSERT, 0, 64'd0, 0, 0);
		add_req(OP_UPSERT, 7, 64'd0, 0, 0);
		add_req(OP_UPSERT, 2, 64'd0, 0, 0);
		add_req(OP_UPSERT, 9, kmax, 0, 0);
		add_req(OP_UPSERT, 1023, 64'd1, 0, 0);
		add_req(OP_UPSERT, 0, kmax - 1, 0, 0);
		add_req(OP_UPSERT, 341, 64'h5555_5555_5555_5555, 0, 0);
		add_req(OP_UPSERT, 682, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0);
		add_req(OP_DELETE, 7, 64'd0, 0, 0);
		add_req(OP_DELETE, 9, kmax, 0, 0);
		add_req(OP_DELETE, 9, 64'd3, 0, 0);
		add_req(OP_UPSERT, 2, kmax, 0, 0);
		// empty the heap again
		foreach (dir_own[i]) add_req(OP_DELETE, dir_own[i], 64'd0, 0, 0, i == 0);

		for (int ph = 0; ph < 4; ph++) begin
			// owner pool small in even phases, full in odd: many updates, equal keys, hits and misses
			for (int i = 0; i < 75; i++) begin
				pool = (ph % 2) ? 1023 : 31;
				add_req($urandom_range(99) < 35 ? OP_DELETE : OP_UPSERT,
					$urandom_range(pool), rand_key(), gaps[ph], stalls[ph], i == 0);
			end
		end
		// fill the heap with every owner, then churn it and delete owners at random
		foreach (order[i]) order[i] = i;
		for (int i = OWNERS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i]; order[i] = order[j]; order[j] = t;
		end
		foreach (order[i]) add_req(OP_UPSERT, order[i], rand_key(), gaps[i % 4],
			stalls[i % 4], i == 0);
		for (int i = 0; i < 60; i++)
			add_req(OP_UPSERT, $urandom_range(1023), rand_key(), 27, 27);
		for (int i = 0; i < 200; i++)
			add_req(OP_DELETE, $urandom_range(1023), rand_key(), 0, 45, i == 0);

		// wait for the run to drain
		while (pending_reqs.size() > 0 || taken_cnt != sent_cnt || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d upserts and %0d deletes (%0d absent), peak heap size %0d,",
			n_upsert, n_delete, n_absent, peak_size);
		$display("%0d responses checked under mixed idle and stall phases", rsp_cnt);
		if (err_cnt == 0 && expected_rsps.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/imh_pkg.sv
hw/rtl/imh_req_if.sv
hw/rtl/imh_rsp_if.sv
hw/rtl/imh_heap_mem.sv
hw/rtl/indexed_min_heap_core.sv
hw/rtl/imh_checker.sv
verif/tb_indexed_min_heap_core.sv
